// ===== rtl/ttb_pkg.sv =====
package ttb_pkg;

   localparam int FIELD_BITS   = 32;
   localparam int OUT_BITS     = 16;
   localparam int NORM_BITS    = 24;
   localparam int GUARD_BITS   = 7;
   localparam int COARSE_SHIFT = 8;
   localparam int SUM_BITS     = 2 * NORM_BITS + 2;
   localparam int ROOT_IN_BITS = SUM_BITS + 2 * GUARD_BITS;
   localparam int ROOT_BITS    = ROOT_IN_BITS / 2;
   localparam int ROOT_STEPS   = ROOT_IN_BITS / 2;
   localparam int CNT_BITS     = 5;
   localparam int MUL_STEPS    = 28;
   localparam int NUM_FIELDS   = 5;

   localparam logic [2:0] TGT_DET   = 3'd0;
   localparam logic [2:0] TGT_TAN_X = 3'd1;
   localparam logic [2:0] TGT_TAN_Y = 3'd2;
   localparam logic [2:0] TGT_TAN_Z = 3'd3;
   localparam logic [2:0] TGT_BIT_X = 3'd4;
   localparam logic [2:0] TGT_BIT_Y = 3'd5;
   localparam logic [2:0] TGT_BIT_Z = 3'd6;

   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] SLOT_BAD    = 2'd3;
   localparam logic [1:0] COMP_LAST   = 2'd2;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] pos_x;
      logic signed [FIELD_BITS-1:0] pos_y;
      logic signed [FIELD_BITS-1:0] pos_z;
      logic signed [FIELD_BITS-1:0] tex_u;
      logic signed [FIELD_BITS-1:0] tex_v;
      logic                         restart;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] tangent_x;
      logic signed [OUT_BITS-1:0] tangent_y;
      logic signed [OUT_BITS-1:0] tangent_z;
      logic signed [OUT_BITS-1:0] bitangent_x;
      logic signed [OUT_BITS-1:0] bitangent_y;
      logic signed [OUT_BITS-1:0] bitangent_z;
      logic                       degenerate;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_NORM_LOAD,
      ST_NORM_SHIFT,
      ST_SQUARE,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       store_corner;
      logic       corner_slot;
      logic       load_delta;
      logic       mul_go;
      logic [2:0] mul_target;
      logic       mul_second;
      logic       mul_half;
      logic       mul_first;
      logic       mul_last;
      logic       norm_load;
      logic       norm_shift;
      logic       vec_sel;
      logic [1:0] comp_idx;
      logic       sq_go;
      logic       sq_first;
      logic       sqrt_load;
      logic       sqrt_step;
      logic       div_load;
      logic       div_step;
      logic       div_last;
      logic       degen_set;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
      logic vec_zero;
      logic norm_done;
   } status_type;

endpackage

// ===== rtl/ttb_ctrl.sv =====
module ttb_ctrl
   import ttb_pkg::*;
#(
   parameter int UNIT_FRAC_BITS = 14
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_restart,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int QUO_BITS = UNIT_FRAC_BITS + 2;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [1:0]          idx_ff, idx_in;
   logic                vec_ff, vec_in;
   logic [1:0]          count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          slot;
   logic                accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot      = (req_restart || count_ff == SLOT_BAD) ? SLOT_FIRST : count_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      vec_in   = vec_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (slot == SLOT_THIRD) begin
                  count_in = SLOT_FIRST;
                  cnt_in   = '0;
                  state_in = ST_MUL;
               end else begin
                  count_in = slot + 2'd1;
               end
            end
         end
         ST_MUL: begin
            if (cnt_ff == CNT_BITS'(MUL_STEPS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            vec_in   = 1'b0;
            state_in = status.det_zero ? ST_OUT : ST_NORM_LOAD;
         end
         ST_NORM_LOAD: begin
            state_in = ST_NORM_SHIFT;
         end
         ST_NORM_SHIFT: begin
            if (status.vec_zero) begin
               state_in = ST_OUT;
            end else if (status.norm_done) begin
               idx_in   = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (idx_ff == COMP_LAST) begin
               state_in = ST_SQRT_INIT;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         ST_SQRT_INIT: begin
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (cnt_ff == CNT_BITS'(ROOT_STEPS - 1)) begin
               idx_in   = '0;
               state_in = ST_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_INIT: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_BITS'(QUO_BITS - 1)) begin
               if (idx_ff != COMP_LAST) begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_DIV_INIT;
               end else if (vec_ff) begin
                  state_in = ST_OUT;
               end else begin
                  vec_in   = 1'b1;
                  state_in = ST_NORM_LOAD;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.vec_sel  = vec_ff;
      cmd.comp_idx = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (slot == SLOT_THIRD) begin
                  cmd.load_delta = 1'b1;
               end else begin
                  cmd.store_corner = 1'b1;
                  cmd.corner_slot  = slot[0];
               end
            end
         end
         ST_MUL: begin
            // Four partial products per target: two terms, low and high half each.
            cmd.mul_go     = 1'b1;
            cmd.mul_target = cnt_ff[4:2];
            cmd.mul_second = cnt_ff[1];
            cmd.mul_half   = cnt_ff[0];
            cmd.mul_first  = (cnt_ff[1:0] == 2'd0);
            cmd.mul_last   = (cnt_ff[1:0] == 2'd3);
         end
         ST_DRAIN: begin
            cmd.degen_set = status.det_zero;
         end
         ST_NORM_LOAD: begin
            cmd.norm_load = 1'b1;
         end
         ST_NORM_SHIFT: begin
            cmd.degen_set  = status.vec_zero;
            cmd.norm_shift = !status.vec_zero && !status.norm_done;
         end
         ST_SQUARE: begin
            cmd.sq_go    = 1'b1;
            cmd.sq_first = (idx_ff == 2'd0);
         end
         ST_SQRT_INIT: begin
            cmd.sqrt_load = 1'b1;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
         end
         ST_DIV_INIT: begin
            cmd.div_load = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_last = (cnt_ff == CNT_BITS'(QUO_BITS - 1));
         end
         ST_OUT: begin
            cmd.out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         vec_ff       <= 1'b0;
         count_ff     <= SLOT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         vec_ff       <= vec_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/ttb_datapath.sv =====
module ttb_datapath
   import ttb_pkg::*;
#(
   parameter int COORD_BITS     = 32,
   parameter int UNIT_FRAC_BITS = 14
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   localparam int DW       = COORD_BITS + 1;
   localparam int LO       = (DW + 1) / 2;
   localparam int HI       = DW - LO;
   localparam int PW       = 2 * DW + 1;
   localparam int QUO_BITS = UNIT_FRAC_BITS + 2;
   localparam int NUM_BITS = NORM_BITS + UNIT_FRAC_BITS + GUARD_BITS + 1;
   localparam int EXT_BITS = (QUO_BITS > OUT_BITS) ? QUO_BITS : OUT_BITS;
   localparam int REM_BITS = ROOT_BITS + 3;

   function automatic logic signed [DW-1:0] coord_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
      logic signed [DW-1:0] ea;
      logic signed [DW-1:0] eb;
      ea = $signed({a[COORD_BITS-1], a});
      eb = $signed({b[COORD_BITS-1], b});
      return ea - eb;
   endfunction

   // Corner storage and deltas.
   logic [FIELD_BITS-1:0] in_coord [NUM_FIELDS];
   logic [COORD_BITS-1:0] c0_ff [NUM_FIELDS];
   logic [COORD_BITS-1:0] c1_ff [NUM_FIELDS];
   logic signed [DW-1:0]  dp1_ff [3];
   logic signed [DW-1:0]  dp2_ff [3];
   logic signed [DW-1:0]  du1_ff, dv1_ff, du2_ff, dv2_ff;

   always_comb begin
      in_coord[0] = req_data.pos_x;
      in_coord[1] = req_data.pos_y;
      in_coord[2] = req_data.pos_z;
      in_coord[3] = req_data.tex_u;
      in_coord[4] = req_data.tex_v;
   end

   always_ff @(posedge clock) begin
      if (cmd.store_corner) begin
         for (int i = 0; i < NUM_FIELDS; i++) begin
            if (cmd.corner_slot) begin
               c1_ff[i] <= in_coord[i][COORD_BITS-1:0];
            end else begin
               c0_ff[i] <= in_coord[i][COORD_BITS-1:0];
            end
         end
      end
      if (cmd.load_delta) begin
         for (int i = 0; i < 3; i++) begin
            dp1_ff[i] <= coord_diff(c1_ff[i], c0_ff[i]);
            dp2_ff[i] <= coord_diff(in_coord[i][COORD_BITS-1:0], c0_ff[i]);
         end
         du1_ff <= coord_diff(c1_ff[3], c0_ff[3]);
         dv1_ff <= coord_diff(c1_ff[4], c0_ff[4]);
         du2_ff <= coord_diff(in_coord[3][COORD_BITS-1:0], c0_ff[3]);
         dv2_ff <= coord_diff(in_coord[4][COORD_BITS-1:0], c0_ff[4]);
      end
   end

   // Shared multiplier: one half-width partial product per cycle, then accumulate.
   logic [1:0]           mul_comp;
   logic signed [DW-1:0] dp1_sel, dp2_sel, mul_x, mul_y;
   logic signed [DW+LO:0]   prod_lo;
   logic signed [DW+HI-1:0] prod_hi;
   logic signed [PW-1:0] pp_in, pp_ff;
   logic                 pp_go_ff;
   logic [2:0]           pp_target_ff;
   logic                 pp_sub_ff, pp_first_ff, pp_last_ff;
   logic signed [PW-1:0] acc_ff, acc_base, acc_in;
   logic signed [PW-1:0] det_ff;
   logic signed [PW-1:0] tv_ff [3];
   logic signed [PW-1:0] bv_ff [3];

   always_comb begin
      unique case (cmd.mul_target)
         TGT_TAN_Y, TGT_BIT_Y: mul_comp = 2'd1;
         TGT_TAN_Z, TGT_BIT_Z: mul_comp = 2'd2;
         default:              mul_comp = 2'd0;
      endcase
   end

   assign dp1_sel = dp1_ff[mul_comp];
   assign dp2_sel = dp2_ff[mul_comp];

   always_comb begin
      if (cmd.mul_target == TGT_DET) begin
         mul_x = cmd.mul_second ? dv1_ff : du1_ff;
         mul_y = cmd.mul_second ? du2_ff : dv2_ff;
      end else if (cmd.mul_target <= TGT_TAN_Z) begin
         mul_x = cmd.mul_second ? dp2_sel : dp1_sel;
         mul_y = cmd.mul_second ? dv1_ff : dv2_ff;
      end else begin
         mul_x = cmd.mul_second ? dp1_sel : dp2_sel;
         mul_y = cmd.mul_second ? du2_ff : du1_ff;
      end
   end

   assign prod_lo = mul_x * $signed({1'b0, mul_y[LO-1:0]});
   assign prod_hi = mul_x * $signed(mul_y[DW-1:LO]);
   assign pp_in   = cmd.mul_half ? (PW'(prod_hi) <<< LO) : PW'(prod_lo);

   assign acc_base = pp_first_ff ? '0 : acc_ff;
   assign acc_in   = pp_sub_ff ? (acc_base - pp_ff) : (acc_base + pp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_go_ff <= 1'b0;
      end else begin
         pp_go_ff <= cmd.mul_go;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff        <= pp_in;
      pp_target_ff <= cmd.mul_target;
      pp_sub_ff    <= cmd.mul_second;
      pp_first_ff  <= cmd.mul_first;
      pp_last_ff   <= cmd.mul_last;
      if (pp_go_ff) begin
         acc_ff <= acc_in;
         if (pp_last_ff) begin
            unique case (pp_target_ff)
               TGT_DET:   det_ff   <= acc_in;
               TGT_TAN_X: tv_ff[0] <= acc_in;
               TGT_TAN_Y: tv_ff[1] <= acc_in;
               TGT_TAN_Z: tv_ff[2] <= acc_in;
               TGT_BIT_X: bv_ff[0] <= acc_in;
               TGT_BIT_Y: bv_ff[1] <= acc_in;
               TGT_BIT_Z: bv_ff[2] <= acc_in;
               default: begin
               end
            endcase
         end
      end
   end

   // Normalizer: shift all magnitudes until the largest is exactly NORM_BITS long.
   logic signed [PW-1:0] vcomp [3];
   logic [PW-1:0]        mag [3];
   logic [PW-1:0]        m_ff [3];
   logic [PW-1:0]        orv;
   logic                 hi_big, hi_any, lo_byte;
   logic [NORM_BITS-1:0] a_sel;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vcomp[i] = cmd.vec_sel ? bv_ff[i] : tv_ff[i];
         mag[i]   = vcomp[i][PW-1] ? PW'(-vcomp[i]) : PW'(vcomp[i]);
      end
   end

   assign orv     = m_ff[0] | m_ff[1] | m_ff[2];
   assign hi_big  = |orv[PW-1:NORM_BITS+COARSE_SHIFT];
   assign hi_any  = |orv[PW-1:NORM_BITS];
   assign lo_byte = |orv[NORM_BITS-1:NORM_BITS-COARSE_SHIFT];
   assign a_sel   = m_ff[cmd.comp_idx][NORM_BITS-1:0];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.norm_load) begin
            m_ff[i] <= mag[i];
         end else if (cmd.norm_shift) begin
            priority if (hi_big) begin
               m_ff[i] <= m_ff[i] >> COARSE_SHIFT;
            end else if (hi_any) begin
               m_ff[i] <= m_ff[i] >> 1;
            end else if (!lo_byte) begin
               m_ff[i] <= m_ff[i] << COARSE_SHIFT;
            end else begin
               m_ff[i] <= m_ff[i] << 1;
            end
         end
      end
   end

   // Sum of squares, then a radix-4 integer square root.
   logic [SUM_BITS-1:0]     s_ff;
   logic [ROOT_IN_BITS-1:0] x_ff;
   logic [REM_BITS-1:0]     rem_ff, rem_sh, trial;
   logic [ROOT_BITS-1:0]    root_ff;

   assign rem_sh = {rem_ff[REM_BITS-3:0], x_ff[ROOT_IN_BITS-1 -: 2]};
   assign trial  = REM_BITS'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (cmd.sq_go) begin
         s_ff <= (cmd.sq_first ? '0 : s_ff) + SUM_BITS'(a_sel) * SUM_BITS'(a_sel);
      end
      if (cmd.sqrt_load) begin
         x_ff    <= {s_ff, {(2 * GUARD_BITS){1'b0}}};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         x_ff <= x_ff << 2;
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   // Restoring divider: rounded a_i * 2^(frac+guard) / n, one quotient bit per cycle.
   logic [NUM_BITS-1:0]  num_in;
   logic [ROOT_BITS-1:0] drem_ff;
   logic [QUO_BITS-1:0]  dnum_ff, q_ff, q_fin, q_cap;
   logic [ROOT_BITS:0]   dt;
   logic                 ge;
   logic [EXT_BITS-1:0]  q_ext;
   logic                 comp_neg;
   logic [OUT_BITS-1:0]  res_val;
   logic [OUT_BITS-1:0]  res_t_ff [3];
   logic [OUT_BITS-1:0]  res_b_ff [3];

   assign num_in = (NUM_BITS'(a_sel) << (UNIT_FRAC_BITS + GUARD_BITS))
                 + NUM_BITS'(root_ff[ROOT_BITS-1:1]);
   assign dt     = {drem_ff, dnum_ff[QUO_BITS-1]};
   assign ge     = (dt >= {1'b0, root_ff});
   assign q_fin  = {q_ff[QUO_BITS-2:0], ge};
   assign q_cap  = (q_fin > (QUO_BITS'(1) << UNIT_FRAC_BITS)) ?
                   (QUO_BITS'(1) << UNIT_FRAC_BITS) : q_fin;
   assign q_ext  = EXT_BITS'(q_cap);
   assign comp_neg = (cmd.vec_sel ? bv_ff[cmd.comp_idx][PW-1] : tv_ff[cmd.comp_idx][PW-1])
                     ^ det_ff[PW-1];
   assign res_val = comp_neg ? OUT_BITS'(-q_ext) : OUT_BITS'(q_ext);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         drem_ff <= ROOT_BITS'(num_in[NUM_BITS-1:QUO_BITS]);
         dnum_ff <= num_in[QUO_BITS-1:0];
         q_ff    <= '0;
      end else if (cmd.div_step) begin
         drem_ff <= ge ? ROOT_BITS'(dt - {1'b0, root_ff}) : dt[ROOT_BITS-1:0];
         dnum_ff <= dnum_ff << 1;
         q_ff    <= q_fin;
         if (cmd.div_last) begin
            if (cmd.vec_sel) begin
               res_b_ff[cmd.comp_idx] <= res_val;
            end else begin
               res_t_ff[cmd.comp_idx] <= res_val;
            end
         end
      end
   end

   // Degenerate flag and result register.
   logic    degen_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         degen_ff <= 1'b0;
      end else if (cmd.load_delta) begin
         degen_ff <= 1'b0;
      end else if (cmd.degen_set) begin
         degen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (degen_ff) begin
            rsp_data_ff.tangent_x   <= '0;
            rsp_data_ff.tangent_y   <= '0;
            rsp_data_ff.tangent_z   <= '0;
            rsp_data_ff.bitangent_x <= '0;
            rsp_data_ff.bitangent_y <= '0;
            rsp_data_ff.bitangent_z <= '0;
            rsp_data_ff.degenerate  <= 1'b1;
         end else begin
            rsp_data_ff.tangent_x   <= res_t_ff[0];
            rsp_data_ff.tangent_y   <= res_t_ff[1];
            rsp_data_ff.tangent_z   <= res_t_ff[2];
            rsp_data_ff.bitangent_x <= res_b_ff[0];
            rsp_data_ff.bitangent_y <= res_b_ff[1];
            rsp_data_ff.bitangent_z <= res_b_ff[2];
            rsp_data_ff.degenerate  <= 1'b0;
         end
      end
   end

   assign rsp_data         = rsp_data_ff;
   assign status.det_zero  = (det_ff == '0);
   assign status.vec_zero  = (orv == '0);
   assign status.norm_done = !hi_any && orv[NORM_BITS-1];

endmodule

// ===== rtl/triangle_tangent_bitangent_top.sv =====
// Per-triangle tangent and bitangent. Vertices arrive three per triangle as requests;
// the first two corners are stored and produce nothing, the third corner
// produces one result holding the unit tangent and bitangent in signed Q1.14 (or a
// degenerate flag with zero vectors). The third corner occupies the block while it runs
// through the single shared 33 x 17 multiplier that forms the fourteen cross
// products in halves, the radix-4 square root and the bit-serial divider that each
// vector's normalization runs through. Corners are stalled while a triangle is
// computed; a finished result waits in the output register while the next corners
// come in.
module triangle_tangent_bitangent_top
   import ttb_pkg::*;
#(
   parameter int COORD_BITS     = 32,
   parameter int UNIT_FRAC_BITS = 14
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   ttb_ctrl #(
      .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_restart(req_data.restart),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   ttb_datapath #(
      .COORD_BITS    (COORD_BITS),
      .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .status  (status),
      .rsp_data(rsp_data)
   );

   // The result register is only overwritten once the previous result has gone.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while still held");

   // The normalizer never shifts a zero vector.
   assert property (@(posedge clock) disable iff (reset)
      cmd.norm_shift |-> !status.vec_zero)
      else $error("normalizer shifting a zero vector");

   // A third corner starts the cross products on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_delta |=> (cmd.mul_go && cmd.mul_first && cmd.mul_target == TGT_DET))
      else $error("cross products did not start after the third corner");

   // A degenerate result carries zero vectors.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |->
         (rsp_data.tangent_x == '0 && rsp_data.tangent_y == '0 &&
          rsp_data.tangent_z == '0 && rsp_data.bitangent_x == '0 &&
          rsp_data.bitangent_y == '0 && rsp_data.bitangent_z == '0))
      else $error("degenerate result with nonzero vectors");

endmodule
